FILE: hdl/hsv_threshold_centroid_macros.svh
// Assertion macros used by the checker of the threshold centroid block.
`ifndef HSV_THRESHOLD_CENTROID_MACROS_SVH
`define HSV_THRESHOLD_CENTROID_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define HTC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define HTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/htc_pkg.sv
// Package with types, constants and helpers of the threshold centroid block.
`timescale 1ns / 1ps
package htc_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_FRAC_BITS  = 4;

    localparam int HSV_SHIFT  = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int OUT_W      = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_HUE_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HUE_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAT_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAT_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VAL_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VAL_HIGH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET   = 3'd6;

    // Reset values of the registers.
    localparam logic [7:0] RST_HUE_LOW  = 8'd35;
    localparam logic [7:0] RST_HUE_HIGH = 8'd85;
    localparam logic [7:0] RST_SAT_LOW  = 8'd100;
    localparam logic [7:0] RST_SAT_HIGH = 8'd255;
    localparam logic [7:0] RST_VAL_LOW  = 8'd100;
    localparam logic [7:0] RST_VAL_HIGH = 8'd255;
    localparam logic [7:0] RST_OFFSET   = 8'd90;

    typedef enum logic [1:0] {
        ST_PIXELS,
        ST_DIVIDE,
        ST_RESULT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic div_start;
        logic result_take;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
    } dp_status_t;

    // Shift-and-subtract quotient, only evaluated when the tables are built.
    function automatic logic [31:0] const_quot(input logic [31:0] num, input logic [31:0] den);
        logic [31:0] q;
        logic [32:0] rem;
        q   = '0;
        rem = '0;
        for (int k = 31; k >= 0; k--)
        begin
            rem = {rem[31:0], num[k]};
            if (rem >= {1'b0, den})
            begin
                rem  = rem - {1'b0, den};
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    // Table of rounded 12-bit reciprocals 255*4096/v (entry 0 is zero).
    function automatic logic [255:0][19:0] build_sat_tab();
        logic [255:0][19:0] t;
        t = '0;
        for (int i = 1; i < 256; i++)
        begin
            t[i] = 20'(const_quot(32'(2 * (255 << HSV_SHIFT) + i), 32'(2 * i)));
        end
        return t;
    endfunction

    // Table of rounded 12-bit reciprocals 30*4096/d (entry 0 is zero).
    function automatic logic [255:0][16:0] build_hue_tab();
        logic [255:0][16:0] t;
        t = '0;
        for (int i = 1; i < 256; i++)
        begin
            t[i] = 17'(const_quot(32'(2 * (30 << HSV_SHIFT) + i), 32'(2 * i)));
        end
        return t;
    endfunction

    localparam logic [255:0][19:0] SAT_RECIP_TAB = build_sat_tab();
    localparam logic [255:0][16:0] HUE_RECIP_TAB = build_hue_tab();

    // Rounded 12-bit reciprocal 255*4096/v (v from 1 to 255).
    function automatic logic [19:0] sat_recip(input logic [7:0] v);
        return SAT_RECIP_TAB[v];
    endfunction

    // Rounded 12-bit reciprocal 30*4096/d (d from 1 to 255).
    function automatic logic [16:0] hue_recip(input logic [7:0] d);
        return HUE_RECIP_TAB[d];
    endfunction

endpackage

FILE: hdl/htc_ctrl.sv
// Controller: pixel acceptance, frame-end division and result handoff.
`timescale 1ns / 1ps
module htc_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_frame_end,
    input  logic                out_ready,
    output logic                in_ready,
    output logic                out_valid,
    output htc_pkg::dp_cmd_t    cmd,
    input  htc_pkg::dp_status_t status
);
    import htc_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_PIXELS;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next      = state_reg;
        in_ready        = 1'b0;
        out_valid       = 1'b0;
        cmd.accept      = 1'b0;
        cmd.div_start   = 1'b0;
        cmd.result_take = 1'b0;
        case (state_reg)
            ST_PIXELS:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && in_frame_end)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (status.div_done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.result_take = 1'b1;
                    state_next      = ST_PIXELS;
                end
            end
            default:
            begin
                state_next = ST_PIXELS;
            end
        endcase
    end

endmodule

FILE: hdl/htc_hsv.sv
// RGB to HSV conversion and threshold test of one pixel.
`timescale 1ns / 1ps
module htc_hsv
(
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    input  logic [7:0] hue_low,
    input  logic [7:0] hue_high,
    input  logic [7:0] sat_low,
    input  logic [7:0] sat_high,
    input  logic [7:0] val_low,
    input  logic [7:0] val_high,
    output logic       pass
);
    import htc_pkg::*;

    logic [7:0]  v, mn, diff, s_val;
    logic signed [11:0] h6;
    logic [27:0] s_prod;
    logic signed [29:0] h_prod, h_rnd;
    logic signed [17:0] h_floor, h_val;

    // Max, min, hue sector, rounded products and the bound compare.
    always_comb
    begin
        v = red;
        if (green > v) v = green;
        if (blue > v) v = blue;
        mn = red;
        if (green < mn) mn = green;
        if (blue < mn) mn = blue;
        diff = v - mn;
        // The blue sector reaches five times the spread, so 12 bits are needed.
        if (v == red)
            h6 = signed'(12'(green)) - signed'(12'(blue));
        else if (v == green)
            h6 = signed'(12'(blue)) - signed'(12'(red)) + signed'(12'({diff, 1'b0}));
        else
            h6 = signed'(12'(red)) - signed'(12'(green)) + signed'(12'({diff, 2'b0}));
        s_prod  = 28'(diff) * 28'(sat_recip(v));
        h_prod  = 30'(h6) * signed'(30'(hue_recip(diff)));
        s_val   = 8'((s_prod + 28'(1 << (HSV_SHIFT - 1))) >> HSV_SHIFT);
        h_rnd   = h_prod + 30'sd2048;
        h_floor = 18'(h_rnd >>> HSV_SHIFT);
        h_val   = (h_floor < 0) ? h_floor + 18'sd180 : h_floor;
        pass    = (h_val[7:0] >= hue_low) && (h_val[7:0] <= hue_high)
               && (s_val >= sat_low) && (s_val <= sat_high)
               && (v >= val_low) && (v <= val_high);
    end
endmodule

FILE: hdl/htc_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module htc_div #(
    parameter int NUM_W = 34,
    parameter int DEN_W = 21
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg;
    logic [DEN_W:0]   rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W+1:0] diffv;

    assign trial = {rem_reg[DEN_W-1:0], q_reg[NUM_W-1]};
    assign diffv = {1'b0, trial} - {2'b0, den_reg};

    // Control of the iteration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                busy_reg <= 1'b0;
        end
    end

    // One shift and subtract step.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            if (!diffv[DEN_W+1])
            begin
                rem_reg <= diffv[DEN_W:0];
                q_reg   <= {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                q_reg   <= {q_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign done = busy_reg && (cnt_reg == CNT_W'(1));
    assign quot = q_reg;
endmodule

FILE: hdl/htc_dp.sv
// Datapath: config, coordinates, sums, dividers and result register.
`timescale 1ns / 1ps
module htc_dp #(
    parameter int MAX_WIDTH  = htc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = htc_pkg::DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = htc_pkg::DEF_FRAC_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           red,
    input  logic [7:0]           green,
    input  logic [7:0]           blue,
    input  logic                 line_end,
    input  logic                 frame_end,
    input  logic                 cfg_wr,
    input  logic [htc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    input  htc_pkg::dp_cmd_t     cmd,
    output htc_pkg::dp_status_t  status,
    output logic [15:0]          centroid_x,
    output logic [15:0]          centroid_y,
    output logic                 object_found
);
    import htc_pkg::*;

    localparam int CX_W  = $clog2(MAX_WIDTH);
    localparam int CY_W  = $clog2(MAX_HEIGHT);
    localparam int HIT_W = CX_W + CY_W + 1;
    localparam int SX_W  = HIT_W + CX_W;
    localparam int SY_W  = HIT_W + CY_W;
    // Both dividers share one numerator width so they finish together.
    localparam int N_W   = ((SX_W > SY_W) ? SX_W : SY_W) + FRAC_BITS;

    logic [7:0] hue_low_reg, hue_high_reg, sat_low_reg, sat_high_reg;
    logic [7:0] val_low_reg, val_high_reg, offset_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_low_reg  <= RST_HUE_LOW;
            hue_high_reg <= RST_HUE_HIGH;
            sat_low_reg  <= RST_SAT_LOW;
            sat_high_reg <= RST_SAT_HIGH;
            val_low_reg  <= RST_VAL_LOW;
            val_high_reg <= RST_VAL_HIGH;
            offset_reg   <= RST_OFFSET;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                REG_HUE_LOW:  hue_low_reg  <= cfg_data;
                REG_HUE_HIGH: hue_high_reg <= cfg_data;
                REG_SAT_LOW:  sat_low_reg  <= cfg_data;
                REG_SAT_HIGH: sat_high_reg <= cfg_data;
                REG_VAL_LOW:  val_low_reg  <= cfg_data;
                REG_VAL_HIGH: val_high_reg <= cfg_data;
                REG_OFFSET:   offset_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pixel classification is combinational, so each item updates the sums at once.
    logic pass;

    htc_hsv u_hsv
    (
        .red(red), .green(green), .blue(blue),
        .hue_low(hue_low_reg), .hue_high(hue_high_reg),
        .sat_low(sat_low_reg), .sat_high(sat_high_reg),
        .val_low(val_low_reg), .val_high(val_high_reg),
        .pass(pass)
    );

    logic [CX_W-1:0]  col_reg;
    logic [CY_W-1:0]  row_reg;
    logic             col_over_reg, row_over_reg;
    logic [HIT_W-1:0] hit_reg;
    logic [SX_W-1:0]  sx_reg;
    logic [SY_W-1:0]  sy_reg;
    logic             hit;

    assign hit = cmd.accept && !col_over_reg && !row_over_reg && pass;

    // Frame state: coordinates and moment sums.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0; row_reg <= '0;
            col_over_reg <= 1'b0; row_over_reg <= 1'b0;
            hit_reg <= '0; sx_reg <= '0; sy_reg <= '0;
        end
        else if (cmd.result_take)
        begin
            hit_reg <= '0; sx_reg <= '0; sy_reg <= '0;
        end
        else if (cmd.accept)
        begin
            if (hit)
            begin
                hit_reg <= hit_reg + 1'b1;
                sx_reg  <= sx_reg + SX_W'(col_reg);
                sy_reg  <= sy_reg + SY_W'(row_reg);
            end
            if (frame_end)
            begin
                col_reg <= '0; row_reg <= '0;
                col_over_reg <= 1'b0; row_over_reg <= 1'b0;
            end
            else if (line_end)
            begin
                col_reg <= '0;
                col_over_reg <= 1'b0;
                if (!row_over_reg)
                begin
                    if (32'(row_reg) + 1 >= MAX_HEIGHT) row_over_reg <= 1'b1;
                    else row_reg <= row_reg + 1'b1;
                end
            end
            else if (!col_over_reg)
            begin
                if (32'(col_reg) + 1 >= MAX_WIDTH) col_over_reg <= 1'b1;
                else col_reg <= col_reg + 1'b1;
            end
        end
    end

    // Dividers start the cycle after the frame's last item updated the sums.
    logic start_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) start_reg <= 1'b0;
        else start_reg <= cmd.div_start;
    end

    logic [N_W-1:0] qx;
    logic [N_W-1:0] qy;
    logic dx, dy;
    logic [HIT_W-1:0] den;
    assign den = (hit_reg == '0) ? HIT_W'(1) : hit_reg;

    htc_div #(.NUM_W(N_W), .DEN_W(HIT_W)) u_div_x
    (
        .clk(clk), .rst_n(rst_n), .start(start_reg),
        .num(N_W'(sx_reg) << FRAC_BITS), .den(den), .done(dx), .quot(qx)
    );
    htc_div #(.NUM_W(N_W), .DEN_W(HIT_W)) u_div_y
    (
        .clk(clk), .rst_n(rst_n), .start(start_reg),
        .num(N_W'(sy_reg) << FRAC_BITS), .den(den), .done(dy), .quot(qy)
    );

    // Next cycle after done the quotient is complete; latch the result then.
    logic fin_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) fin_reg <= 1'b0;
        else fin_reg <= dx && dy;
    end
    assign status.div_done = fin_reg;

    logic [31:0] off;
    assign off = 32'(offset_reg) << FRAC_BITS;

    always_ff @(posedge clk)
    begin
        if (fin_reg)
        begin
            if (hit_reg != '0)
            begin
                centroid_x   <= 16'(32'(qx) + off);
                centroid_y   <= 16'(32'(qy) + off);
                object_found <= 1'b1;
            end
            else
            begin
                centroid_x   <= 16'(-(32'(1) << FRAC_BITS));
                centroid_y   <= 16'(-(32'(1) << FRAC_BITS));
                object_found <= 1'b0;
            end
        end
    end
endmodule

FILE: hdl/hsv_threshold_centroid.sv
// Top level of the HSV threshold centroid block.
// Pixels are taken one per clock while a frame streams in; each passing pixel
// adds its column and row to running sums in the same cycle. On the frame's
// last item two restoring dividers (one quotient bit a cycle) form the means.
// Their numerator has 2*log2(max(MAX_WIDTH, MAX_HEIGHT)) + log2(MAX_HEIGHT or
// MAX_WIDTH) + 1 + FRAC_BITS bits (35 at the default 1024 by 1024 and four
// fraction bits). The divider start is registered, and the result item is
// valid once both quotients are complete and registered. No new pixel
// is taken until the result item has been read. Configuration writes are
// always accepted but belong between frames, while no result is pending.
`timescale 1ns / 1ps
module hsv_threshold_centroid #(
    parameter int MAX_WIDTH  = htc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = htc_pkg::DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = htc_pkg::DEF_FRAC_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red, green, blue
    input  logic        s_axis_tlast,   // frame_end
    input  logic        s_axis_tuser,   // line_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // centroid_x, centroid_y
    output logic        m_axis_tuser,   // object_found
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [htc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]  cfg_data
);
    import htc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic [15:0] cx, cy;

    assign cfg_ready = 1'b1;

    htc_ctrl u_ctrl
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_frame_end(s_axis_tlast),
        .out_ready(m_axis_tready), .in_ready(s_axis_tready),
        .out_valid(m_axis_tvalid), .cmd(cmd), .status(status)
    );

    htc_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .FRAC_BITS(FRAC_BITS)) u_dp
    (
        .clk(clk), .rst_n(rst_n),
        .red(s_axis_tdata[7:0]), .green(s_axis_tdata[15:8]), .blue(s_axis_tdata[23:16]),
        .line_end(s_axis_tuser), .frame_end(s_axis_tlast),
        .cfg_wr(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .cmd(cmd), .status(status),
        .centroid_x(cx), .centroid_y(cy), .object_found(m_axis_tuser)
    );

    assign m_axis_tdata = {cy, cx};
endmodule

FILE: hdl/htc_checker.sv
// Port-level checker for the threshold centroid block, with its bind.
`timescale 1ns / 1ps
`include "hsv_threshold_centroid_macros.svh"
module htc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    // No pixel is taken while a result waits.
    `HTC_ASSERT_IMP(a_no_in_with_out, clk, rst_n, m_axis_tvalid, !s_axis_tready)
    // A frame's last item closes the input side next cycle.
    `HTC_ASSERT_NEXT(a_close, clk, rst_n, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready)
    // A result that is not found carries minus one in fixed point, a negative value, in both fields.
    `HTC_ASSERT_IMP(a_empty, clk, rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[15] && m_axis_tdata[31])
    // Taking the result reopens the input side.
    `HTC_ASSERT_NEXT(a_reopen, clk, rst_n, m_axis_tvalid && m_axis_tready, s_axis_tready)
endmodule

bind hsv_threshold_centroid htc_checker u_htc_checker
(
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tlast(s_axis_tlast), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
